// ----- sv/spt_pkg.sv -----
package spt_pkg;

    localparam int VAL_W     = 16;
    localparam int GAIN_W    = 16;
    localparam int DRIVE_W   = 32;
    localparam int CFG_IDX_W = 2;

    // Position loop widths
    localparam int ERR_W  = VAL_W + 1;
    localparam int DERR_W = ERR_W + 1;
    localparam int PINT_W = 14;
    localparam int ONE_Q12 = 4096;

    // Torque loop widths
    localparam int AVG_TAPS = 5;
    localparam int HIST_LEN = AVG_TAPS - 1;
    localparam int SAMP_W   = VAL_W + 1;
    localparam int SUM_W    = SAMP_W + $clog2(AVG_TAPS);
    localparam int TERR_W   = VAL_W + 2;
    localparam int TINT_W   = 32;
    localparam int TQO_W    = 14;
    localparam int SP_SHIFT = 10;

    // Divide by the tap count as a multiply by a rounded-up reciprocal
    localparam int DIV_SHIFT = SUM_W + 5;
    localparam int DIV_MULT  = (2 ** DIV_SHIFT + AVG_TAPS - 1) / AVG_TAPS;
    localparam int DIV_PROD_W = SUM_W + DIV_SHIFT;

    // Product sums and their floored Q.12 forms
    localparam int FLOOR_SHIFT = 8;
    localparam int POS_S_W = 36;
    localparam int POS_O_W = POS_S_W - FLOOR_SHIFT;
    localparam int TQ_S_W  = 50;
    localparam int TQ_F_W  = TQ_S_W - FLOOR_SHIFT;

    typedef enum logic [1:0] {
        CMD_SETPOINT = 2'd0,
        CMD_POSITION = 2'd1,
        CMD_TORQUE   = 2'd2,
        CMD_COMBINED = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN  = CFG_IDX_W'(0),
        REG_DERIV_GAIN = CFG_IDX_W'(1),
        REG_INTEG_GAIN = CFG_IDX_W'(2)
    } cfg_idx_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'b00,
        DIR_FWD  = 2'b01,
        DIR_REV  = 2'b11
    } dir_t;

endpackage

// ----- sv/spt_cfg_if.sv -----
interface spt_cfg_if;
    import spt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [GAIN_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/spt_item_if.sv -----
interface spt_item_if;
    import spt_pkg::*;

    logic                    valid;
    logic                    ready;
    cmd_t                    cmd;
    logic signed [VAL_W-1:0] target;
    logic signed [VAL_W-1:0] position;
    logic signed [VAL_W-1:0] current;

    modport source (output valid, cmd, target, position, current, input ready);
    modport sink   (input valid, cmd, target, position, current, output ready);
endinterface

// ----- sv/spt_result_if.sv -----
interface spt_result_if;
    import spt_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive;

    modport source (output valid, drive, input ready);
    modport sink   (input valid, drive, output ready);
endinterface

// ----- sv/servo_pid_with_torque_loop.sv -----
// Channel   Dir   Payload                          Transfer
// cfg       in    index, data                      valid & ready (ready always high)
// item      in    cmd, target, position, current   valid & ready
// result    out   drive                            valid & ready
//
// One item per cycle unless held by a stalled result or this hazard: a torque
// or combined step directly behind another torque or combined step waits while
// the item ahead is in the product stage, whose multipliers give the drive
// direction its current sign needs. Items pass the input, product and output
// registers; setpoint items give no result. rst_n clears all loop state, the
// gains go to their defaults. A stalled result holds in the output register
// while the earlier stages keep taking items until they fill.
module servo_pid_with_torque_loop (
    input  logic          clk,
    input  logic          rst_n,
    spt_cfg_if.sink       cfg,
    spt_item_if.sink      item,
    spt_result_if.source  result
);
    import spt_pkg::*;

    localparam logic signed [PINT_W-1:0]  PINT_MAX = PINT_W'(ONE_Q12);
    localparam logic signed [PINT_W-1:0]  PINT_MIN = -PINT_W'(ONE_Q12);
    localparam logic signed [TQO_W-1:0]   TQ_MAX   = TQO_W'(ONE_Q12);
    localparam logic signed [TQO_W-1:0]   TQ_MIN   = -TQO_W'(ONE_Q12);
    localparam logic signed [TINT_W-1:0]  TINT_MAX = {1'b0, {(TINT_W-1){1'b1}}};
    localparam logic signed [TINT_W-1:0]  TINT_MIN = {1'b1, {(TINT_W-1){1'b0}}};
    localparam logic [DIV_PROD_W-1:0]     DIV_MULT_V = DIV_PROD_W'(DIV_MULT);

    function automatic logic is_torque(input cmd_t c);
        return (c == CMD_TORQUE) || (c == CMD_COMBINED);
    endfunction

    function automatic logic is_position(input cmd_t c);
        return (c == CMD_POSITION) || (c == CMD_COMBINED);
    endfunction

    // Configuration
    logic [GAIN_W-1:0] prop_gain_reg;
    logic [GAIN_W-1:0] deriv_gain_reg;
    logic [GAIN_W-1:0] integ_gain_reg;

    // Input stage
    logic                    in_valid_reg;
    cmd_t                    in_cmd_reg;
    logic signed [VAL_W-1:0] in_target_reg;
    logic signed [VAL_W-1:0] in_position_reg;
    logic signed [VAL_W-1:0] in_current_reg;

    // Product stage
    logic                     mid_valid_reg;
    logic                     mid_valid_next;
    cmd_t                     mid_cmd_reg;
    logic signed [ERR_W-1:0]  mid_err_reg;
    logic signed [DERR_W-1:0] mid_derr_reg;
    logic signed [PINT_W-1:0] mid_pint_reg;
    logic signed [TERR_W-1:0] mid_terr_reg;
    logic signed [TINT_W-1:0] mid_tint_reg;
    logic signed [VAL_W-1:0]  mid_setpoint_reg;

    // Output stage
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [DRIVE_W-1:0] out_drive_reg;

    // Loop state
    logic signed [VAL_W-1:0]  setpoint_reg;
    logic signed [ERR_W-1:0]  prev_error_reg;
    logic signed [PINT_W-1:0] pos_integral_reg;
    logic signed [TINT_W-1:0] torque_integral_reg;
    logic signed [SAMP_W-1:0] samples_reg [HIST_LEN];
    dir_t                     drive_sign_reg;
    dir_t                     drive_sign_next;

    // Handshake control
    logic out_free;
    logic mid_free;
    logic mid_adv;
    logic hazard;
    logic in_fire;
    logic item_xfer;

    assign out_free  = !out_valid_reg || result.ready;
    assign mid_adv   = mid_valid_reg && out_free;
    assign mid_free  = !mid_valid_reg || out_free;
    assign hazard    = is_torque(in_cmd_reg) && mid_valid_reg && is_torque(mid_cmd_reg);
    assign in_fire   = in_valid_reg &&
                       ((in_cmd_reg == CMD_SETPOINT) || (mid_free && !hazard));
    assign item_xfer = item.valid && item.ready;

    assign item.ready   = !in_valid_reg || in_fire;
    assign cfg.ready    = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.drive = out_drive_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= GAIN_W'(256);
            deriv_gain_reg <= '0;
            integ_gain_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_PROP_GAIN:  prop_gain_reg  <= cfg.data;
                REG_DERIV_GAIN: deriv_gain_reg <= cfg.data;
                REG_INTEG_GAIN: integ_gain_reg <= cfg.data;
                default:        ;
            endcase
        end
    end

    // ---------------- input stage arithmetic ----------------
    logic signed [ERR_W-1:0]    pos_err;
    logic signed [DERR_W-1:0]   pint_sum;
    logic signed [PINT_W-1:0]   pint_new;
    logic signed [DERR_W-1:0]   pos_derr;
    logic signed [SAMP_W-1:0]   cur_ext;
    logic signed [SAMP_W-1:0]   tq_samp;
    logic signed [SUM_W-1:0]    tq_sum;
    logic                       tq_sum_neg;
    logic [SUM_W-1:0]           tq_abs;
    logic [DIV_PROD_W-1:0]      div_prod;
    logic [SUM_W-1:0]           tq_quot;
    logic signed [SUM_W-1:0]    tq_avg;
    logic signed [TERR_W-1:0]   tq_err;
    logic signed [TINT_W:0]     tint_sum;
    logic signed [TINT_W-1:0]   tint_new;

    always_comb
    begin
        pos_err  = ERR_W'(setpoint_reg) - ERR_W'(in_position_reg);
        pint_sum = DERR_W'(pos_integral_reg) + DERR_W'(pos_err);
        if (pint_sum > DERR_W'(PINT_MAX))
            pint_new = PINT_MAX;
        else if (pint_sum < DERR_W'(PINT_MIN))
            pint_new = PINT_MIN;
        else
            pint_new = PINT_W'(pint_sum);
        pos_derr = DERR_W'(pos_err) - DERR_W'(prev_error_reg);
    end

    always_comb
    begin
        cur_ext = SAMP_W'(in_current_reg);
        tq_samp = (drive_sign_reg == DIR_REV) ? -cur_ext : cur_ext;
        tq_sum  = SUM_W'(tq_samp);
        for (int i = 0; i < HIST_LEN; i++)
            tq_sum = tq_sum + SUM_W'(samples_reg[i]);

        // Truncating division: divide the magnitude, then restore the sign
        tq_sum_neg = tq_sum[SUM_W-1];
        tq_abs     = tq_sum_neg ? $unsigned(-tq_sum) : $unsigned(tq_sum);
        div_prod   = DIV_PROD_W'(tq_abs) * DIV_MULT_V;
        tq_quot    = div_prod[DIV_SHIFT +: SUM_W];
        tq_avg     = tq_sum_neg ? -$signed(tq_quot) : $signed(tq_quot);

        tq_err   = TERR_W'(setpoint_reg) - TERR_W'(tq_avg);
        tint_sum = (TINT_W+1)'(torque_integral_reg) + (TINT_W+1)'(tq_err);
        if (tint_sum > (TINT_W+1)'(TINT_MAX))
            tint_new = TINT_MAX;
        else if (tint_sum < (TINT_W+1)'(TINT_MIN))
            tint_new = TINT_MIN;
        else
            tint_new = TINT_W'(tint_sum);
    end

    // ---------------- product stage arithmetic ----------------
    logic signed [GAIN_W:0]    kp_s;
    logic signed [GAIN_W:0]    kd_s;
    logic signed [GAIN_W:0]    ki_s;
    logic signed [POS_S_W-1:0] pos_s;
    logic signed [POS_O_W-1:0] pos_out;
    logic signed [TQ_S_W-1:0]  tq_s;
    logic signed [TQ_F_W-1:0]  tq_floor;
    logic signed [TQO_W-1:0]   tq_out;
    logic signed [DRIVE_W-1:0] drive_out;

    always_comb
    begin
        kp_s = $signed({1'b0, prop_gain_reg});
        kd_s = $signed({1'b0, deriv_gain_reg});
        ki_s = $signed({1'b0, integ_gain_reg});

        pos_s = POS_S_W'(kp_s) * POS_S_W'(mid_err_reg)
              + POS_S_W'(kd_s) * POS_S_W'(mid_derr_reg)
              + POS_S_W'(ki_s) * POS_S_W'(mid_pint_reg);
        // Dropping the low bits of a two's complement value floors it
        pos_out = pos_s[POS_S_W-1:FLOOR_SHIFT];

        tq_s = (TQ_S_W'(mid_setpoint_reg) <<< SP_SHIFT)
             + TQ_S_W'(kp_s) * TQ_S_W'(mid_terr_reg)
             + TQ_S_W'(ki_s) * TQ_S_W'(mid_tint_reg);
        tq_floor = tq_s[TQ_S_W-1:FLOOR_SHIFT];
        if (tq_floor > TQ_F_W'(TQ_MAX))
            tq_out = TQ_MAX;
        else if (tq_floor < TQ_F_W'(TQ_MIN))
            tq_out = TQ_MIN;
        else
            tq_out = TQO_W'(tq_floor);

        // Position result stays within 28 bits, so the sum cannot overflow
        case (mid_cmd_reg)
            CMD_POSITION: drive_out = DRIVE_W'(pos_out);
            CMD_TORQUE:   drive_out = DRIVE_W'(tq_out);
            CMD_COMBINED: drive_out = DRIVE_W'(pos_out) + DRIVE_W'(tq_out);
            default:      drive_out = '0;
        endcase
    end

    always_comb
    begin
        drive_sign_next = drive_sign_reg;
        if (mid_adv && is_torque(mid_cmd_reg))
        begin
            if (tq_floor[TQ_F_W-1])
                drive_sign_next = DIR_REV;
            else if (tq_floor != '0)
                drive_sign_next = DIR_FWD;
        end
    end

    always_comb
    begin
        if (in_fire && (in_cmd_reg != CMD_SETPOINT))
            mid_valid_next = 1'b1;
        else if (mid_adv)
            mid_valid_next = 1'b0;
        else
            mid_valid_next = mid_valid_reg;

        if (mid_adv)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // ---------------- control and loop state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg        <= 1'b0;
            mid_valid_reg       <= 1'b0;
            out_valid_reg       <= 1'b0;
            setpoint_reg        <= '0;
            prev_error_reg      <= '0;
            pos_integral_reg    <= '0;
            torque_integral_reg <= '0;
            drive_sign_reg      <= DIR_NONE;
            for (int i = 0; i < HIST_LEN; i++)
                samples_reg[i] <= '0;
        end
        else
        begin
            if (item_xfer)
                in_valid_reg <= 1'b1;
            else if (in_fire)
                in_valid_reg <= 1'b0;
            mid_valid_reg  <= mid_valid_next;
            out_valid_reg  <= out_valid_next;
            drive_sign_reg <= drive_sign_next;

            if (in_fire)
            begin
                if (in_cmd_reg == CMD_SETPOINT)
                begin
                    setpoint_reg        <= in_target_reg;
                    pos_integral_reg    <= '0;
                    torque_integral_reg <= '0;
                end
                if (is_position(in_cmd_reg))
                begin
                    pos_integral_reg <= pint_new;
                    prev_error_reg   <= pos_err;
                end
                if (is_torque(in_cmd_reg))
                begin
                    torque_integral_reg <= tint_new;
                    // Advance the sample line, newest at the top
                    for (int i = 0; i < HIST_LEN - 1; i++)
                        samples_reg[i] <= samples_reg[i+1];
                    samples_reg[HIST_LEN-1] <= tq_samp;
                end
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            in_cmd_reg      <= item.cmd;
            in_target_reg   <= item.target;
            in_position_reg <= item.position;
            in_current_reg  <= item.current;
        end
        if (in_fire && (in_cmd_reg != CMD_SETPOINT))
        begin
            mid_cmd_reg      <= in_cmd_reg;
            mid_err_reg      <= pos_err;
            mid_derr_reg     <= pos_derr;
            mid_pint_reg     <= pint_new;
            mid_terr_reg     <= tq_err;
            mid_tint_reg     <= tint_new;
            mid_setpoint_reg <= setpoint_reg;
        end
        if (mid_adv)
            out_drive_reg <= drive_out;
    end

    // ---------------- assertions ----------------
    a_pint_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_integral_reg <= PINT_MAX) && (pos_integral_reg >= PINT_MIN))
        else $error("position integral outside +-1.0");

    a_mid_moves: assert property (@(posedge clk) disable iff (!rst_n)
        mid_valid_reg && out_free |=> out_valid_reg)
        else $error("product stage item lost on its way to the output");

    a_setpoint_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (in_cmd_reg == CMD_SETPOINT)
        |=> (pos_integral_reg == '0) && (torque_integral_reg == '0))
        else $error("setpoint did not clear the integrals");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> item.ready)
        else $error("empty input stage refuses a transfer");

endmodule
